[design/htpr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the hash table probe block.
// No dependencies; every other file of the block but htpr_ram imports this package.
package htpr_pkg;

  // Default sizes for the top level parameters
  localparam int DEF_SLOT_COUNT     = 16;
  localparam int DEF_MAX_NAME_BYTES = 8;

  // Fixed payload widths
  localparam int FUNC_W   = 1;
  localparam int NAME_W   = 64;
  localparam int LEN_W    = 4;
  localparam int NUM_W    = 50;
  localparam int STATUS_W = 3;
  localparam int CMP_W    = 5;
  localparam int SLOT_W   = 4;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_RECORDS = 3'd4;

  // Contents of a freshly cleared slot: "----", length four, free
  localparam logic [NAME_W-1:0] RESET_NAME = 64'h0000_0000_2D2D_2D2D;
  localparam logic [LEN_W-1:0]  RESET_LEN  = 4'd4;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
    logic [NUM_W-1:0]  num;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_WAIT,
    S_CHK,
    S_OCC_HASH,
    S_FREE_WAIT,
    S_FREE_CHK,
    S_MOVE,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_NEW,
    WR_OCC
  } wr_src_t;

  typedef enum logic [1:0] {
    WA_CLEAR,
    WA_HOME,
    WA_PROBE
  } wr_at_t;

  typedef enum logic [1:0] {
    PA_NONE,
    PA_HOME,
    PA_PROBE
  } pend_at_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                load;
    logic                hash_step;
    logic                hash_occ;
    logic                occ_latch;
    logic                probe_next;
    logic                wr_en;
    wr_src_t             wr_src;
    wr_at_t              wr_at;
    logic                clr_step;
    logic                pend_set;
    logic [STATUS_W-1:0] pend_status;
    pend_at_t            pend_at;
    logic                pend_disp;
    logic                out_load;
  } cmd_t;

  localparam cmd_t CMD_NONE = '{
    load:        1'b0,
    hash_step:   1'b0,
    hash_occ:    1'b0,
    occ_latch:   1'b0,
    probe_next:  1'b0,
    wr_en:       1'b0,
    wr_src:      WR_CLEAR,
    wr_at:       WA_CLEAR,
    clr_step:    1'b0,
    pend_set:    1'b0,
    pend_status: ST_INSERTED,
    pend_at:     PA_NONE,
    pend_disp:   1'b0,
    out_load:    1'b0
  };

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_search;
    logic never_inserted;
    logic hash_last;
    logic clr_last;
    logic rd_free;
    logic name_match;
    logic occ_at_home;
    logic cnt_full;
    logic cnt_over;
    logic out_free;
  } sts_t;

endpackage

[design/htpr_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result words.
// Depends on htpr_pkg for the payload widths.
interface htpr_req_if import htpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NAME_W-1:0] name_bytes;
  logic [LEN_W-1:0]  name_length;
  logic [NUM_W-1:0]  phone_number;

  modport source (output valid, func, name_bytes, name_length, phone_number,
                  input ready);
  modport sink   (input valid, func, name_bytes, name_length, phone_number,
                  output ready);
endinterface

interface htpr_rsp_if import htpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NUM_W-1:0]    found_number;
  logic [CMP_W-1:0]    comparisons;
  logic [SLOT_W-1:0]   slot;
  logic                displaced;

  modport source (output valid, status, found_number, comparisons, slot, displaced,
                  input ready);
  modport sink   (input valid, status, found_number, comparisons, slot, displaced,
                  output ready);
endinterface

[design/htpr_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency.
module htpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/htpr_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences hashing, probing, slot writes and results.
// Depends on htpr_pkg for the state, command and status types.
module htpr_ctrl import htpr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_src   = WR_CLEAR;
        cmd.wr_at    = WA_CLEAR;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.is_search) begin
          if (sts.never_inserted) begin
            cmd.pend_set    = 1'b1;
            cmd.pend_status = ST_NO_RECORDS;
            state_next      = S_RESULT;
          end else if (sts.name_match) begin
            cmd.pend_set    = 1'b1;
            cmd.pend_status = ST_FOUND;
            cmd.pend_at     = PA_PROBE;
            state_next      = S_RESULT;
          end else if (sts.cnt_over) begin
            cmd.pend_set    = 1'b1;
            cmd.pend_status = ST_NOT_FOUND;
            state_next      = S_RESULT;
          end else begin
            cmd.probe_next = 1'b1;
            state_next     = S_WAIT;
          end
        end else if (sts.rd_free) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_src      = WR_NEW;
          cmd.wr_at       = WA_HOME;
          cmd.pend_set    = 1'b1;
          cmd.pend_status = ST_INSERTED;
          cmd.pend_at     = PA_HOME;
          state_next      = S_RESULT;
        end else begin
          cmd.occ_latch = 1'b1;
          state_next    = S_OCC_HASH;
        end
      end
      S_OCC_HASH: begin
        cmd.hash_step = 1'b1;
        cmd.hash_occ  = 1'b1;
        if (sts.hash_last) begin
          state_next = S_FREE_WAIT;
        end
      end
      S_FREE_WAIT: begin
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (sts.rd_free) begin
          cmd.wr_en = 1'b1;
          cmd.wr_at = WA_PROBE;
          if (sts.occ_at_home) begin
            cmd.wr_src      = WR_NEW;
            cmd.pend_set    = 1'b1;
            cmd.pend_status = ST_INSERTED;
            cmd.pend_at     = PA_PROBE;
            state_next      = S_RESULT;
          end else begin
            cmd.wr_src = WR_OCC;
            state_next = S_MOVE;
          end
        end else if (sts.cnt_full) begin
          cmd.pend_set    = 1'b1;
          cmd.pend_status = ST_FULL;
          state_next      = S_RESULT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_FREE_WAIT;
        end
      end
      S_MOVE: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_src      = WR_NEW;
        cmd.wr_at       = WA_HOME;
        cmd.pend_set    = 1'b1;
        cmd.pend_status = ST_INSERTED;
        cmd.pend_at     = PA_HOME;
        cmd.pend_disp   = 1'b1;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[design/htpr_dp.sv]
`timescale 1ns / 1ps
// Datapath: request registers, byte-serial hash, probe counter, slot RAM and
// result registers. Depends on htpr_pkg and htpr_ram.
module htpr_dp import htpr_pkg::*; #(
  parameter int SLOT_COUNT     = DEF_SLOT_COUNT,
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [NAME_W-1:0]   in_name,
  input  logic [LEN_W-1:0]    in_len,
  input  logic [NUM_W-1:0]    in_num,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [NUM_W-1:0]    out_number,
  output logic [CMP_W-1:0]    out_cmp,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_disp
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 2);
  localparam int BIDX_W = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

  // Request registers
  logic [FUNC_W-1:0] func_r;
  logic [NAME_W-1:0] name_r;
  logic [LEN_W-1:0]  len_r;
  logic [NUM_W-1:0]  num_r;

  // Occupant of the home slot
  logic [NAME_W-1:0] occ_name;
  logic [LEN_W-1:0]  occ_len;
  logic [NUM_W-1:0]  occ_num;

  logic [IDX_W-1:0]  acc;
  logic [BIDX_W-1:0] bidx;
  logic [IDX_W-1:0]  home;
  logic [IDX_W-1:0]  occ_home;
  logic [IDX_W-1:0]  probe;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  clr_addr;
  logic              never_inserted;

  logic [STATUS_W-1:0] pend_status;
  logic [NUM_W-1:0]    pend_number;
  logic [CMP_W-1:0]    pend_cmp;
  logic [SLOT_W-1:0]   pend_slot;
  logic                pend_disp;

  logic [LEN_W-1:0]  len_sat;
  logic [NAME_W-1:0] name_masked;
  logic [NAME_W-1:0] hash_src;
  logic [7:0]        hash_byte;
  logic [IDX_W:0]    hash_sum;
  logic [IDX_W-1:0]  hash_next;
  logic              hash_last;
  logic [IDX_W-1:0]  byte_mod [256];

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  logic [ENTRY_W-1:0] rd_bits;

  logic [IDX_W+3:0]  home_wide;
  logic [IDX_W+3:0]  probe_wide;
  logic [CNT_W+4:0]  cnt_wide;

  // Byte residues modulo the table size, fixed at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_byte_mod
    assign byte_mod[g] = IDX_W'(g % SLOT_COUNT);
  end

  // Saturate the length and zero the bytes past it
  always_comb begin
    len_sat = (in_len > LEN_W'(MAX_NAME_BYTES)) ? LEN_W'(MAX_NAME_BYTES) : in_len;
    for (int i = 0; i < NAME_W / 8; i++) begin
      name_masked[8*i +: 8] = (LEN_W'(i) < len_sat) ? in_name[8*i +: 8] : 8'h00;
    end
  end

  // One name byte per cycle, residue kept below the table size
  assign hash_src  = cmd.hash_occ ? occ_name : name_r;
  assign hash_byte = hash_src[{bidx, 3'b000} +: 8];
  assign hash_sum  = {1'b0, acc} + {1'b0, byte_mod[hash_byte]};
  assign hash_next = (hash_sum >= (IDX_W + 1)'(SLOT_COUNT))
                   ? IDX_W'(hash_sum - (IDX_W + 1)'(SLOT_COUNT))
                   : hash_sum[IDX_W-1:0];
  assign hash_last = (bidx == BIDX_W'(MAX_NAME_BYTES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      name_r <= name_masked;
      len_r  <= len_sat;
      num_r  <= in_num;
      acc    <= '0;
      bidx   <= '0;
    end
    if (cmd.occ_latch) begin
      occ_name <= rd_data.name;
      occ_len  <= rd_data.len;
      occ_num  <= rd_data.num;
      acc      <= '0;
      bidx     <= '0;
    end
    if (cmd.hash_step) begin
      acc  <= hash_next;
      bidx <= bidx + BIDX_W'(1);
      if (hash_last) begin
        cnt <= CNT_W'(1);
        if (cmd.hash_occ) begin
          occ_home <= hash_next;
          probe    <= home;
        end else begin
          home  <= hash_next;
          probe <= hash_next;
        end
      end
    end
    if (cmd.probe_next) begin
      probe <= (probe == IDX_W'(SLOT_COUNT - 1)) ? '0 : probe + IDX_W'(1);
      cnt   <= cnt + CNT_W'(1);
    end
    if (cmd.pend_set) begin
      pend_status <= cmd.pend_status;
      pend_disp   <= cmd.pend_disp;
      pend_number <= (cmd.pend_status == ST_FOUND) ? rd_data.num : '0;
      pend_cmp    <= (cmd.pend_status == ST_FOUND || cmd.pend_status == ST_NOT_FOUND)
                   ? cnt_wide[CMP_W-1:0] : '0;
      case (cmd.pend_at)
        PA_HOME:  pend_slot <= home_wide[SLOT_W-1:0];
        PA_PROBE: pend_slot <= probe_wide[SLOT_W-1:0];
        default:  pend_slot <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_status <= pend_status;
      out_number <= pend_number;
      out_cmp    <= pend_cmp;
      out_slot   <= pend_slot;
      out_disp   <= pend_disp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      never_inserted <= 1'b1;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.load && in_func == FUNC_INSERT) begin
        never_inserted <= 1'b0;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign home_wide  = {4'd0, home};
  assign probe_wide = {4'd0, probe};
  assign cnt_wide   = {5'd0, cnt};

  // Slot write port
  always_comb begin
    wr_en = cmd.wr_en;
    case (cmd.wr_src)
      WR_NEW:  wr_data = '{name: name_r, len: len_r, num: num_r};
      WR_OCC:  wr_data = '{name: occ_name, len: occ_len, num: occ_num};
      default: wr_data = '{name: RESET_NAME, len: RESET_LEN, num: '0};
    endcase
    case (cmd.wr_at)
      WA_HOME:  wr_addr = home;
      WA_PROBE: wr_addr = probe;
      default:  wr_addr = clr_addr;
    endcase
  end

  htpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (probe),
    .rd_data (rd_bits)
  );

  assign rd_data = entry_t'(rd_bits);

  assign sts.is_search      = (func_r == FUNC_SEARCH);
  assign sts.never_inserted = never_inserted;
  assign sts.hash_last      = hash_last;
  assign sts.clr_last       = (clr_addr == IDX_W'(SLOT_COUNT - 1));
  assign sts.rd_free        = (rd_data.num == '0);
  assign sts.name_match     = (rd_data.num != '0) && (rd_data.len == len_r)
                           && (rd_data.name == name_r);
  assign sts.occ_at_home    = (occ_home == home);
  assign sts.cnt_full       = (cnt == CNT_W'(SLOT_COUNT));
  assign sts.cnt_over       = (cnt == CNT_W'(SLOT_COUNT + 1));
  assign sts.out_free       = !out_valid || out_ready;

endmodule

[design/hash_table_probe_with_replacement_top.sv]
`timescale 1ns / 1ps
// Top level of the linear probing hash table with replacement.
// Depends on htpr_pkg, htpr_ifs, htpr_ctrl, htpr_dp (and htpr_ram below it).
// Usage: req carries one word per operation: func selects insert or search,
//   the name is up to MAX_NAME_BYTES bytes (first byte lowest), phone_number
//   is stored on insert. rsp returns exactly one word per request: status,
//   found number, comparison count, slot and the displaced flag. A word moves
//   on either channel at a rising edge with valid and ready high.
// Sequence: one request at a time. The home slot is a byte-serial sum of
//   the MAX_NAME_BYTES name bytes; each probe of the slot RAM sets the
//   address, then reads the registered read data. A colliding insert adds
//   a hash of the occupant, a scan for a free slot and, when the occupant
//   moves, a write of the new entry to the home slot.
// Reset: rst is synchronous. After it the block sweeps the slot RAM, one slot
//   per cycle, with req.ready low; then every slot holds the empty entry and
//   searches report no records until the first insert.
// Stalls: the result sits in an output register; while rsp.ready is low the
//   block still takes the next request and holds its finished result until
//   the register frees up.
module hash_table_probe_with_replacement_top import htpr_pkg::*; #(
  parameter int SLOT_COUNT     = DEF_SLOT_COUNT,
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
  input logic      clk,
  input logic      rst,
  htpr_req_if.sink req,
  htpr_rsp_if.source rsp
);

  // Command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  htpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath owns the slot RAM and the result register that drives rsp
  htpr_dp #(
    .SLOT_COUNT     (SLOT_COUNT),
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (req.func),
    .in_name    (req.name_bytes),
    .in_len     (req.name_length),
    .in_num     (req.phone_number),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_number (rsp.found_number),
    .out_cmp    (rsp.comparisons),
    .out_slot   (rsp.slot),
    .out_disp   (rsp.displaced)
  );

endmodule
